// ===== rtl/ppm_dec_pkg.sv =====
// Package for the PPM pulse decoder: configuration register indexes, reset
// values, the configuration bundle type and index-wrap constants.
// No dependencies.
`default_nettype none

package ppm_dec_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int INDEX_SLOTS  = 16;
	localparam int IDX_W        = 4;
	localparam int CNT_W        = 5;
	localparam int VAL_W        = 16;
	localparam int TIME_W       = 32;
	localparam int CFG_IDX_W    = 3;

	localparam int IDX_LIMIT_INT = (MAX_CHANNELS < INDEX_SLOTS) ? MAX_CHANNELS : INDEX_SLOTS;
	localparam logic [CNT_W-1:0] IDX_LIMIT = CNT_W'(IDX_LIMIT_INT);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 3'd0,
		REG_SYNC_GAP      = 3'd1,
		REG_HIGH_LIMIT    = 3'd2,
		REG_LOW_LIMIT     = 3'd3,
		REG_FOLD_OFFSET   = 3'd4
	} cfg_reg_t;

	localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 5'd9;
	localparam logic [VAL_W-1:0] SYNC_GAP_RESET      = 16'd3000;
	localparam logic [VAL_W-1:0] HIGH_LIMIT_RESET    = 16'd2000;
	localparam logic [VAL_W-1:0] LOW_LIMIT_RESET     = 16'd1000;
	localparam logic [VAL_W-1:0] FOLD_OFFSET_RESET   = 16'd1000;

	typedef struct packed {
		logic [CNT_W-1:0] channel_count;
		logic [VAL_W-1:0] sync_gap;
		logic [VAL_W-1:0] high_limit;
		logic [VAL_W-1:0] low_limit;
		logic [VAL_W-1:0] fold_offset;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ppm_dec_cfg.sv =====
// Configuration register file of the PPM pulse decoder.
// Decodes writes from the configuration channel into the cfg_t bundle.
// Depends on ppm_dec_pkg.
`default_nettype none

module ppm_dec_cfg
	import ppm_dec_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [VAL_W-1:0]     cfg_data,
	output logic                      cfg_ready,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= CHANNEL_COUNT_RESET;
			cfg_q.sync_gap      <= SYNC_GAP_RESET;
			cfg_q.high_limit    <= HIGH_LIMIT_RESET;
			cfg_q.low_limit     <= LOW_LIMIT_RESET;
			cfg_q.fold_offset   <= FOLD_OFFSET_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CNT_W-1:0];
				REG_SYNC_GAP:      cfg_q.sync_gap      <= cfg_data;
				REG_HIGH_LIMIT:    cfg_q.high_limit    <= cfg_data;
				REG_LOW_LIMIT:     cfg_q.low_limit     <= cfg_data;
				REG_FOLD_OFFSET:   cfg_q.fold_offset   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ppm_pulse_decoder_top.sv =====
// Top level of the PPM pulse decoder: edge state, gap folding and result register.
// Depends on ppm_dec_pkg and ppm_dec_cfg.
//
// Usage: each item on the input channel (in_valid/in_ready) is the microsecond
// timestamp of one rising edge. Each accepted item yields exactly one result
// item on the output channel (out_valid/out_ready): the channel slot, its
// folded value, a frame flag and the held frame period.
// A result is valid in the cycle after its item is taken.
// Throughput is one item per cycle while out_ready holds; the edge state and
// result register both update in the cycle of acceptance, so no gap is needed.
// While a result waits, a new item is still accepted in the cycle the result
// is taken, as in_ready follows out_ready when the result register is full.
// The configuration channel (cfg_valid/cfg_ready) is always ready; the user must
// write it only while idle (not enforced by the block); unknown indexes are ignored.
// Reset restores the register defaults, clears the edge and sync timestamps,
// the channel slot and the held period, and empties the result register.
`default_nettype none

module ppm_pulse_decoder_top
	import ppm_dec_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [VAL_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [TIME_W-1:0]    edge_time,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [IDX_W-1:0]          channel_index,
	output logic [VAL_W-1:0]          channel_value,
	output logic                      frame_start,
	output logic [TIME_W-1:0]         frame_period
);

	cfg_t cfg;

	logic [TIME_W-1:0] last_edge_q;
	logic [TIME_W-1:0] last_sync_q;
	logic [IDX_W-1:0]  cur_chan_q;
	logic [TIME_W-1:0] held_period_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [VAL_W-1:0]  out_value_q;
	logic              out_start_q;
	logic [TIME_W-1:0] out_period_q;

	logic              accept;
	logic [TIME_W-1:0] gap;
	logic [VAL_W-1:0]  gap16;
	logic              is_sync;
	logic [CNT_W-1:0]  next_n;
	logic [IDX_W-1:0]  next_chan;
	logic [VAL_W:0]    gap_plus;
	logic [VAL_W-1:0]  fold_val;
	logic [VAL_W-1:0]  value;
	logic [TIME_W-1:0] period;

	ppm_dec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		gap      = edge_time - last_edge_q;
		gap16    = gap[VAL_W-1:0];
		is_sync  = gap > {{(TIME_W-VAL_W){1'b0}}, cfg.sync_gap};
		next_n   = {1'b0, cur_chan_q} + CNT_W'(1);
		if (next_n >= cfg.channel_count || next_n >= IDX_LIMIT) begin
			next_chan = '0;
		end else begin
			next_chan = next_n[IDX_W-1:0];
		end
		// A channel gap never exceeds sync_gap, so its low half is the whole gap.
		gap_plus = {1'b0, gap16} + {1'b0, cfg.fold_offset};
		if (gap16 > cfg.high_limit) begin
			fold_val = (gap16 > cfg.fold_offset) ? gap16 - cfg.fold_offset : '0;
		end else if (gap16 < cfg.low_limit) begin
			fold_val = gap_plus[VAL_W] ? {VAL_W{1'b1}} : gap_plus[VAL_W-1:0];
		end else begin
			fold_val = gap16;
		end
		if (is_sync) begin
			value  = (|gap[TIME_W-1:VAL_W]) ? {VAL_W{1'b1}} : gap16;
			period = edge_time - last_sync_q;
		end else begin
			value  = fold_val;
			period = held_period_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q   <= '0;
			last_sync_q   <= '0;
			cur_chan_q    <= '0;
			held_period_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				last_edge_q   <= edge_time;
				held_period_q <= period;
				if (is_sync) begin
					last_sync_q <= edge_time;
					cur_chan_q  <= '0;
				end else begin
					cur_chan_q  <= next_chan;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_index_q  <= is_sync ? '0 : next_chan;
			out_value_q  <= value;
			out_start_q  <= is_sync;
			out_period_q <= period;
		end
	end

	assign out_valid     = out_valid_q;
	assign channel_index = out_index_q;
	assign channel_value = out_value_q;
	assign frame_start   = out_start_q;
	assign frame_period  = out_period_q;

	a_sync_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_start |-> channel_index == '0)
		else $error("sync result carries a non-zero channel slot");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, channel_index} < IDX_LIMIT)
		else $error("channel slot beyond the slot limit");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while a stalled result waits");

	a_period_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_sync |=> frame_period == $past(held_period_q))
		else $error("frame period changed without a sync");

endmodule

`default_nettype wire
